// ===== sv/fccr_pkg.sv =====
package fccr_pkg;

  localparam int unsigned BLOCK_BYTES  = 512;
  localparam int unsigned TOTAL_BLOCKS = 16;
  localparam int unsigned MAX_STEPS    = 14;
  localparam int unsigned DATA_START   = 3;

  localparam int unsigned TBL_DEPTH = 512;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned STEP_W    = $clog2(MAX_STEPS + 1);

  localparam int unsigned LBA_W  = 8;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned CLU_W  = 16;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned CAP_W  = 16;
  localparam int unsigned ENT_W  = 12;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_SEG,
    ST_FETCH_LO,
    ST_FETCH_HI,
    ST_LINK,
    ST_TEST,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic clr_wr;
    logic tbl_wr;
    logic load;
    logic set_nomatch;
    logic set_zero;
    logic seg_calc;
    logic rd_lo;
    logic rd_hi;
    logic link;
    logic mark_last;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic match;
    logic cap_zero;
    logic cluster_ok;
    logic done;
    logic next_ok;
    logic steps_max;
    logic seg_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/fccr_dp.sv =====
module fccr_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fccr_pkg::cmd_t                    cmd_i,
  output fccr_pkg::sts_t                    sts_o,
  input  logic [fccr_pkg::TBL_AW-1:0]       table_address_i,
  input  logic [7:0]                        table_byte_i,
  input  logic                              name_matches_i,
  input  logic [fccr_pkg::CLU_W-1:0]        start_cluster_i,
  input  logic [fccr_pkg::SIZE_W-1:0]       file_size_i,
  input  logic [fccr_pkg::CAP_W-1:0]        capacity_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [fccr_pkg::LBA_W-1:0]        sector_lba_o,
  output logic [fccr_pkg::CNT_W-1:0]        byte_count_o,
  output logic [fccr_pkg::OFF_W-1:0]        out_offset_o,
  output logic                              last_o
);
  import fccr_pkg::*;

  logic [7:0]        mem_q [TBL_DEPTH];
  logic [7:0]        rd_data_q;
  logic [TBL_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic              mem_we;
  logic [TBL_AW-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [TBL_AW-1:0] mem_raddr;

  logic              match_q;
  logic [CLU_W-1:0]  cluster_q;
  logic [SIZE_W-1:0] size_q;
  logic [CAP_W-1:0]  cap_q;
  logic [OFF_W-1:0]  copied_q;
  logic [STEP_W-1:0] steps_q;
  logic [7:0]        lo_q;

  logic [LBA_W-1:0]  seg_lba_q;
  logic [CNT_W-1:0]  seg_cnt_q;
  logic [OFF_W-1:0]  seg_off_q;
  logic              seg_last_q;

  logic              out_valid_q;
  logic [LBA_W-1:0]  out_lba_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [OFF_W-1:0]  out_off_q;
  logic              out_last_q;

  logic [CLU_W:0]    lba_full;
  logic [CLU_W:0]    entry_pos;
  logic [SIZE_W-1:0] rem_size;
  logic [CAP_W-1:0]  rem_cap;
  logic [CAP_W-1:0]  n_blk;
  logic [CAP_W-1:0]  n_seg;
  logic [CAP_W-1:0]  n_nomatch;
  logic [ENT_W-1:0]  next_ent;

  assign lba_full  = {1'b0, cluster_q} + (CLU_W+1)'(DATA_START) - (CLU_W+1)'(2);
  assign entry_pos = {1'b0, cluster_q} + {2'b0, cluster_q[CLU_W-1:1]};

  assign rem_size  = size_q - {{(SIZE_W-OFF_W){1'b0}}, copied_q};
  assign rem_cap   = cap_q - copied_q;
  assign n_blk     = (rem_size < SIZE_W'(BLOCK_BYTES)) ? rem_size[CAP_W-1:0]
                                                       : CAP_W'(BLOCK_BYTES);
  assign n_seg     = (n_blk < rem_cap) ? n_blk : rem_cap;
  assign n_nomatch = (cap_q < CAP_W'(BLOCK_BYTES)) ? cap_q : CAP_W'(BLOCK_BYTES);

  assign next_ent  = cluster_q[0] ? {rd_data_q, lo_q[7:4]} : {rd_data_q[3:0], lo_q};

  assign mem_we    = cmd_i.clr_wr | cmd_i.tbl_wr;
  assign mem_waddr = cmd_i.clr_wr ? clr_cnt_q : table_address_i;
  assign mem_wdata = cmd_i.clr_wr ? 8'h00 : table_byte_i;
  assign mem_raddr = cmd_i.rd_hi ? entry_pos[TBL_AW-1:0] + TBL_AW'(1)
                                 : entry_pos[TBL_AW-1:0];
  assign clr_cnt_d = clr_cnt_q + TBL_AW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (cmd_i.rd_lo || cmd_i.rd_hi) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      match_q   <= name_matches_i;
      cluster_q <= start_cluster_i;
      size_q    <= (file_size_i == '0) ? SIZE_W'(BLOCK_BYTES) : file_size_i;
      cap_q     <= capacity_i;
      copied_q  <= '0;
      steps_q   <= '0;
    end
    if (cmd_i.set_nomatch) begin
      seg_lba_q  <= LBA_W'(DATA_START);
      seg_cnt_q  <= n_nomatch[CNT_W-1:0];
      seg_off_q  <= '0;
      seg_last_q <= 1'b1;
    end
    if (cmd_i.set_zero) begin
      seg_lba_q  <= '0;
      seg_cnt_q  <= '0;
      seg_off_q  <= '0;
      seg_last_q <= 1'b1;
    end
    if (cmd_i.seg_calc) begin
      seg_lba_q  <= lba_full[LBA_W-1:0];
      seg_cnt_q  <= n_seg[CNT_W-1:0];
      seg_off_q  <= copied_q;
      seg_last_q <= 1'b0;
      copied_q   <= copied_q + n_seg;
    end
    if (cmd_i.rd_hi) begin
      lo_q <= rd_data_q;
    end
    if (cmd_i.link) begin
      cluster_q <= {{(CLU_W-ENT_W){1'b0}}, next_ent};
      steps_q   <= steps_q + STEP_W'(1);
    end
    if (cmd_i.mark_last) begin
      seg_last_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      out_lba_q  <= seg_lba_q;
      out_cnt_q  <= seg_cnt_q;
      out_off_q  <= seg_off_q;
      out_last_q <= seg_last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.clr_last   = (clr_cnt_q == TBL_AW'(TBL_DEPTH - 1));
    sts_o.match      = match_q;
    sts_o.cap_zero   = (cap_q == '0);
    sts_o.cluster_ok = (cluster_q >= CLU_W'(2)) && (lba_full < (CLU_W+1)'(TOTAL_BLOCKS));
    sts_o.done       = ({{(SIZE_W-OFF_W){1'b0}}, copied_q} >= size_q) || (copied_q >= cap_q);
    sts_o.next_ok    = (next_ent >= ENT_W'(2));
    sts_o.steps_max  = (steps_q == STEP_W'(MAX_STEPS));
    sts_o.seg_last   = seg_last_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign sector_lba_o = out_lba_q;
  assign byte_count_o = out_cnt_q;
  assign out_offset_o = out_off_q;
  assign last_o       = out_last_q;

  a_emit_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("segment pushed over a held transfer");

  a_emit_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (seg_cnt_q <= CNT_W'(BLOCK_BYTES)))
    else $error("segment byte count exceeds block size");

  a_seg_on_valid_cluster : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seg_calc |-> (sts_o.cluster_ok && !sts_o.done))
    else $error("segment computed on invalid cluster or finished walk");

  a_fetch_not_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_lo |=> (cmd_i.rd_hi && !cmd_i.emit))
    else $error("table fetch not followed by high byte read");

endmodule

// ===== sv/fccr_ctrl.sv =====
module fccr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           operation_i,
  output fccr_pkg::cmd_t cmd_o,
  input  fccr_pkg::sts_t sts_i
);
  import fccr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (operation_i == OP_WRITE) begin
            cmd_o.tbl_wr = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (!sts_i.match) begin
          cmd_o.set_nomatch = 1'b1;
          state_d           = ST_EMIT;
        end else if (!sts_i.cluster_ok || sts_i.cap_zero) begin
          cmd_o.set_zero = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          state_d = ST_SEG;
        end
      end
      ST_SEG: begin
        cmd_o.seg_calc = 1'b1;
        state_d        = ST_FETCH_LO;
      end
      ST_FETCH_LO: begin
        if (sts_i.done) begin
          cmd_o.mark_last = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.rd_lo = 1'b1;
          state_d     = ST_FETCH_HI;
        end
      end
      ST_FETCH_HI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = ST_LINK;
      end
      ST_LINK: begin
        if (!sts_i.next_ok) begin
          cmd_o.mark_last = 1'b1;
          state_d         = ST_EMIT;
        end else begin
          cmd_o.link = 1'b1;
          state_d    = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts_i.steps_max || !sts_i.cluster_ok) begin
          cmd_o.mark_last = 1'b1;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.seg_last ? ST_IDLE : ST_SEG;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_clear_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_wr |-> (in_stall_o && !cmd_o.tbl_wr))
    else $error("input taken during table clear");

  a_link_then_test : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.link |=> (state_q == ST_TEST))
    else $error("chain link not followed by cluster test");

  a_load_then_check : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CHECK && in_stall_o))
    else $error("read request not followed by entry check");

endmodule

// ===== sv/fat12_cluster_chain_reader_top.sv =====
// Table byte write: accepted while idle, next item may follow at once.
// Read request: no match, a bad start cluster or zero capacity gives one segment,
// else each segment takes size, two table reads (skipped when done), link, cluster
// test and emit; output stalls can hold this. Up to 14 segments, one read at a time.
// After reset the 512-byte table is cleared one byte per cycle,
// with the input stalled; the output register resets to empty.
module fat12_cluster_chain_reader_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         operation_i,
  input  logic [fccr_pkg::TBL_AW-1:0]  table_address_i,
  input  logic [7:0]                   table_byte_i,
  input  logic                         name_matches_i,
  input  logic [fccr_pkg::CLU_W-1:0]   start_cluster_i,
  input  logic [fccr_pkg::SIZE_W-1:0]  file_size_i,
  input  logic [fccr_pkg::CAP_W-1:0]   capacity_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fccr_pkg::LBA_W-1:0]   sector_lba_o,
  output logic [fccr_pkg::CNT_W-1:0]   byte_count_o,
  output logic [fccr_pkg::OFF_W-1:0]   out_offset_o,
  output logic                         last_o
);
  import fccr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fccr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  fccr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .table_address_i (table_address_i),
    .table_byte_i    (table_byte_i),
    .name_matches_i  (name_matches_i),
    .start_cluster_i (start_cluster_i),
    .file_size_i     (file_size_i),
    .capacity_i      (capacity_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sector_lba_o    (sector_lba_o),
    .byte_count_o    (byte_count_o),
    .out_offset_o    (out_offset_o),
    .last_o          (last_o)
  );

endmodule
